/* rtl/ismf_pkg.sv */
// ============================================================================
// ismf_pkg: shared types and constants of the set membership filter
// Command codes, field widths and the transaction token that walks the cells.
// ============================================================================
package ismf_pkg;

    localparam int KEY_W            = 32;
    localparam int IDX_W            = 24;
    localparam int CMD_W            = 2;
    localparam int SET_SIZE_DEFAULT = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef struct packed {
        logic             valid;
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
        logic             hit;
        logic             done;
    } tok_t;

endpackage

/* rtl/ismf_cell.sv */
// ============================================================================
// ismf_cell: one set entry
// Holds one key, compares the passing token against it, takes the key of an
// add at the first free entry, and hands the token to the next cell.
// ============================================================================
module ismf_cell #(
    parameter int CW = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  ismf_pkg::tok_t  tok_in,
    input  logic [CW-1:0]   rem_in,
    output ismf_pkg::tok_t  tok_out,
    output logic [CW-1:0]   rem_out
);
    import ismf_pkg::*;

    logic [KEY_W-1:0] key_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic [CW-1:0]    rem_reg;
    logic [CW-1:0]    rem_next;
    logic             occupied;
    logic             match;
    logic             write_en;

    always_comb
    begin
        occupied = (rem_in != '0);
        match    = occupied && (key_reg == tok_in.key);
        write_en = tok_in.valid && (tok_in.cmd == CMD_ADD) && !occupied
                   && !tok_in.hit && !tok_in.done;
        tok_next      = tok_in;
        tok_next.hit  = tok_in.hit | match;
        tok_next.done = tok_in.done | write_en;
        rem_next      = occupied ? (rem_in - CW'(1)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            rem_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && write_en)
        begin
            key_reg <= tok_in.key;
        end
    end

    assign tok_out = tok_reg;
    assign rem_out = rem_reg;

endmodule

/* rtl/ismf_chain.sv */
// ============================================================================
// ismf_chain: row of set entry cells
// Links SET_SIZE cells so that a token moves one entry per cycle while advance is high.
// ============================================================================
module ismf_chain #(
    parameter int SET_SIZE = ismf_pkg::SET_SIZE_DEFAULT,
    parameter int CW       = $clog2(SET_SIZE + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  ismf_pkg::tok_t  tok_in,
    input  logic [CW-1:0]   rem_in,
    output ismf_pkg::tok_t  tok_out
);
    import ismf_pkg::*;

    tok_t          tok_link [SET_SIZE+1];
    logic [CW-1:0] rem_link [SET_SIZE+1];

    assign tok_link[0] = tok_in;
    assign rem_link[0] = rem_in;

    for (genvar i = 0; i < SET_SIZE; i++)
    begin : g_cell
        ismf_cell #(
            .CW (CW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (tok_link[i]),
            .rem_in  (rem_link[i]),
            .tok_out (tok_link[i+1]),
            .rem_out (rem_link[i+1])
        );
    end

    assign tok_out = tok_link[SET_SIZE];

endmodule

/* rtl/integer_set_membership_filter_unit.sv */
// ============================================================================
// integer_set_membership_filter_unit: duplicate-free key set with query filter
// Clear, add and query transactions on a row of key cells; matching queries
// return their item index together with the sticky overflow flag.
// ============================================================================
// One transaction is in flight at a time. A clear, or an unused command code,
// leaves in_ready high. An add or a query walks the row of SET_SIZE cells one
// cell per cycle while the row is not held, and the next transaction is taken
// once its token leaves the end of the row. A finished query result waits in
// the output register while the next transaction is taken, and the walk of a
// later matching query holds at the end of the row until that register frees.
module integer_set_membership_filter_unit #(
    parameter int SET_SIZE = ismf_pkg::SET_SIZE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ismf_pkg::CMD_W-1:0]      command,
    input  logic signed [ismf_pkg::KEY_W-1:0] key_value,
    input  logic [ismf_pkg::IDX_W-1:0]      item_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ismf_pkg::IDX_W-1:0]      matched_index,
    output logic                            set_overflowed
);
    import ismf_pkg::*;

    localparam int CW = $clog2(SET_SIZE + 1);

    logic             busy_reg;
    logic             busy_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [IDX_W-1:0] matched_reg;
    logic             out_ovf_reg;

    logic             in_fire;
    logic             is_clear;
    logic             is_walk;
    logic             end_hit;
    logic             advance;
    logic             end_take;
    logic             out_load;
    tok_t             tok_head;
    tok_t             tok_tail;

    assign in_ready = !busy_reg;
    assign in_fire  = in_valid && in_ready;
    assign is_clear = (command == CMD_CLEAR);
    assign is_walk  = (command == CMD_ADD) || (command == CMD_QUERY);

    always_comb
    begin
        tok_head.valid = in_fire && is_walk;
        tok_head.cmd   = cmd_t'(command);
        tok_head.key   = $unsigned(key_value);
        tok_head.idx   = item_index;
        tok_head.hit   = 1'b0;
        tok_head.done  = 1'b0;
    end

    ismf_chain #(
        .SET_SIZE (SET_SIZE),
        .CW       (CW)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .tok_in  (tok_head),
        .rem_in  (count_reg),
        .tok_out (tok_tail)
    );

    always_comb
    begin
        end_hit  = tok_tail.valid && (tok_tail.cmd == CMD_QUERY) && tok_tail.hit;
        advance  = !(end_hit && out_valid_reg && !out_ready);
        end_take = tok_tail.valid && advance;
        out_load = end_take && end_hit;

        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (in_fire && is_clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (end_take && (tok_tail.cmd == CMD_ADD))
        begin
            if (tok_tail.done)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (!tok_tail.hit)
            begin
                ovf_next = 1'b1;
            end
        end

        busy_next = busy_reg;
        if (in_fire && is_walk)
        begin
            busy_next = 1'b1;
        end
        else if (end_take)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            matched_reg <= tok_tail.idx;
            out_ovf_reg <= ovf_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign matched_index  = matched_reg;
    assign set_overflowed = out_ovf_reg;

endmodule
